// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that property p implies q on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, p, q, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (p) |-> (q)) \
        else $error(msg);

// Assert that a property p holds at the next edge after condition c.
`define ASSERT_NEXT(label, clk, rst_n, c, p, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (c) |=> (p)) \
        else $error(msg);

`endif

// ===== sv/rmq_pkg.sv =====
package rmq_pkg;
    // Component magnitudes: trace+1 is at most 3*32767+2^30 for the widest
    // fraction setting; 33 bits hold any component, 66 its square.
    localparam int CW = 34;
    localparam int SW = 70;
    localparam int QBITS = 15;
    localparam int QMAX = 32767;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] w;
        logic                 degen;
    } comp_t;
endpackage

// ===== sv/rmq_front.sv =====
// Branch selection and integer quaternion components, one register stage.
module rmq_front #(
    parameter int IN_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                en,
    input  logic [143:0]        mat,
    output rmq_pkg::comp_t      comp
);
    import rmq_pkg::*;

    logic signed [CW-1:0] m [9];
    logic signed [CW-1:0] one, tr, arg;
    logic [1:0] i_sel;
    comp_t comp_next, comp_reg;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
            m[n] = CW'($signed(mat[n*16 +: 16]));
        one = CW'(1) <<< IN_FRAC_BITS;
        tr = m[0] + m[4] + m[8];
        i_sel = 2'd0;
        if (m[4] > m[0]) i_sel = 2'd1;
        if (m[8] > ((i_sel == 2'd1) ? m[4] : m[0])) i_sel = 2'd2;
        comp_next = '0;
        arg = '0;
        if (tr > 0)
        begin
            comp_next.x = m[5] - m[7];
            comp_next.y = m[6] - m[2];
            comp_next.z = m[1] - m[3];
            comp_next.w = tr + one;
        end
        else
        begin
            case (i_sel)
                2'd0:
                begin
                    arg = m[0] - (m[4] + m[8]) + one;
                    comp_next.x = arg;
                    comp_next.y = m[1] + m[3];
                    comp_next.z = m[2] + m[6];
                    comp_next.w = m[5] - m[7];
                end
                2'd1:
                begin
                    arg = m[4] - (m[8] + m[0]) + one;
                    comp_next.y = arg;
                    comp_next.z = m[5] + m[7];
                    comp_next.x = m[3] + m[1];
                    comp_next.w = m[6] - m[2];
                end
                default:
                begin
                    arg = m[8] - (m[0] + m[4]) + one;
                    comp_next.z = arg;
                    comp_next.x = m[6] + m[2];
                    comp_next.y = m[7] + m[5];
                    comp_next.w = m[1] - m[3];
                end
            endcase
            if (arg <= 0)
            begin
                comp_next = '0;
                comp_next.degen = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
        if (en) comp_reg <= comp_next;

    assign comp = comp_reg;
endmodule

// ===== sv/rmq_sumsq.sv =====
// Squares then sum of squares, two register stages.
module rmq_sumsq (
    input  logic                      clk,
    input  logic                      en,
    input  rmq_pkg::comp_t            comp_in,
    output logic [rmq_pkg::SW-1:0]    sum,
    output logic [4*rmq_pkg::SW-1:0]  rhs,
    output rmq_pkg::comp_t            comp_out
);
    import rmq_pkg::*;

    logic [CW-1:0] a [4];
    logic [SW-1:0] sq_reg [4];
    logic [SW-1:0] sum_reg;
    logic [4*SW-1:0] rhs_reg;
    comp_t c1_reg, c2_reg;

    always_comb
    begin
        a[0] = comp_in.x[CW-1] ? CW'(-comp_in.x) : comp_in.x;
        a[1] = comp_in.y[CW-1] ? CW'(-comp_in.y) : comp_in.y;
        a[2] = comp_in.z[CW-1] ? CW'(-comp_in.z) : comp_in.z;
        a[3] = comp_in.w[CW-1] ? CW'(-comp_in.w) : comp_in.w;
    end

    always_ff @(posedge clk)
        if (en)
        begin
            for (int n = 0; n < 4; n++)
                sq_reg[n] <= SW'(a[n]) * SW'(a[n]);
            c1_reg <= comp_in;
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
            for (int n = 0; n < 4; n++)
                rhs_reg[n*SW +: SW] <= sq_reg[n];
            c2_reg <= c1_reg;
        end

    assign sum = sum_reg;
    assign rhs = rhs_reg;
    assign comp_out = c2_reg;
endmodule

// ===== sv/rmq_isqrt.sv =====
// One bit of floor(32767*|c|/sqrt(s)) per stage: keep t if t^2*s <= c^2*32767^2.
// q^2*s and q*s ride along, so a trial t = q + 2^b needs only shifts and adds:
// t^2*s = q^2*s + (q*s << (b+1)) + (s << 2b).
module rmq_isqrt (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rmq_pkg::SW-1:0]    sum,
    input  logic [4*rmq_pkg::SW-1:0]  csq,
    input  rmq_pkg::comp_t            comp_in,
    output logic [4*rmq_pkg::QBITS-1:0] q,
    output rmq_pkg::comp_t            comp_out
);
    import rmq_pkg::*;

    localparam int RW = SW + 30;
    localparam int NS = QBITS + 1;

    logic [SW-1:0]        s_reg  [NS];
    logic [RW-1:0]        r_reg  [NS][4];
    logic [RW-1:0]        p_reg  [NS][4];
    logic [RW-1:0]        qs_reg [NS][4];
    logic [QBITS-1:0]     q_reg  [NS][4];
    comp_t                c_reg  [NS];
    logic [RW-1:0]        p_try  [NS-1][4];
    logic                 keep   [NS-1][4];

    always_comb
        for (int st = 1; st < NS; st++)
            for (int n = 0; n < 4; n++)
            begin
                p_try[st-1][n] = p_reg[st-1][n] + (qs_reg[st-1][n] << (QBITS - st + 1))
                                 + (RW'(s_reg[st-1]) << (2 * (QBITS - st)));
                keep[st-1][n] = p_try[st-1][n] <= r_reg[st-1][n];
            end

    always_ff @(posedge clk)
        if (en)
        begin
            s_reg[0] <= sum;
            c_reg[0] <= comp_in;
            for (int n = 0; n < 4; n++)
            begin
                // 32767^2 = 2^30 - 2^16 + 1
                r_reg[0][n] <= (RW'(csq[n*SW +: SW]) << 30)
                               - (RW'(csq[n*SW +: SW]) << 16)
                               + RW'(csq[n*SW +: SW]);
                p_reg[0][n] <= '0;
                qs_reg[0][n] <= '0;
                q_reg[0][n] <= '0;
            end
            for (int st = 1; st < NS; st++)
            begin
                s_reg[st] <= s_reg[st-1];
                c_reg[st] <= c_reg[st-1];
                for (int n = 0; n < 4; n++)
                begin
                    r_reg[st][n] <= r_reg[st-1][n];
                    if (keep[st-1][n])
                    begin
                        p_reg[st][n] <= p_try[st-1][n];
                        qs_reg[st][n] <= qs_reg[st-1][n]
                                         + (RW'(s_reg[st-1]) << (QBITS - st));
                        q_reg[st][n] <= q_reg[st-1][n] | (QBITS'(1) << (QBITS - st));
                    end
                    else
                    begin
                        p_reg[st][n] <= p_reg[st-1][n];
                        qs_reg[st][n] <= qs_reg[st-1][n];
                        q_reg[st][n] <= q_reg[st-1][n];
                    end
                end
            end
        end

    always_comb
        for (int n = 0; n < 4; n++)
            q[n*QBITS +: QBITS] = q_reg[NS-1][n];

    assign comp_out = c_reg[NS-1];
endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion, fully pipelined.
// Input stream s_axis: one 3x3 matrix per transaction, nine signed Q2.14
// entries. Output stream m_axis: x, y, z, w scaled by 32767, truncated
// toward zero, and the degenerate flag in tuser (identity substituted).
// Twenty register stages: one for branch selection, two for squares and sum,
// sixteen for the bitwise normalization, one output register. Throughput is
// one transaction per cycle while the output is not stalled.
// When the output stalls the whole pipeline holds and s_axis_tready drops
// in the same cycle; valid bits ride along, nothing is lost or repeated.
// Reset clears all valid bits; no result is pending afterwards.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion #(
    parameter int IN_FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic         m_axis_tuser    // degenerate
);
    import rmq_pkg::*;

    localparam int DEPTH = 20;

    logic [DEPTH-1:0] vld_reg;
    logic en;
    comp_t c_a, c_b, c_c;
    logic [SW-1:0] sum;
    logic [4*SW-1:0] csq;
    logic [4*QBITS-1:0] qv;
    logic [15:0] o [4];
    logic [63:0] tdata_reg;
    logic tuser_reg;

    // advance when the last slot is empty or being taken
    assign en = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};

    rmq_front #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_front (
        .clk(clk), .en(en), .mat(s_axis_tdata), .comp(c_a));

    rmq_sumsq u_sumsq (
        .clk(clk), .en(en), .comp_in(c_a), .sum(sum), .rhs(csq), .comp_out(c_b));

    rmq_isqrt u_isqrt (
        .clk(clk), .en(en), .sum(sum), .csq(csq), .comp_in(c_b), .q(qv),
        .comp_out(c_c));

    always_comb
    begin
        o[0] = c_c.x[CW-1] ? 16'(-$signed({1'b0, qv[0 +: QBITS]})) : {1'b0, qv[0 +: QBITS]};
        o[1] = c_c.y[CW-1] ? 16'(-$signed({1'b0, qv[15 +: QBITS]})) : {1'b0, qv[15 +: QBITS]};
        o[2] = c_c.z[CW-1] ? 16'(-$signed({1'b0, qv[30 +: QBITS]})) : {1'b0, qv[30 +: QBITS]};
        o[3] = c_c.w[CW-1] ? 16'(-$signed({1'b0, qv[45 +: QBITS]})) : {1'b0, qv[45 +: QBITS]};
    end

    always_ff @(posedge clk)
        if (en)
        begin
            if (c_c.degen)
                tdata_reg <= {16'(QMAX), 48'd0};
            else
                tdata_reg <= {o[3], o[2], o[1], o[0]};
            tuser_reg <= c_c.degen;
        end

    assign m_axis_tdata = tdata_reg;
    assign m_axis_tuser = tuser_reg;

    `ASSERT_IMPL(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready, "pipeline advanced during output stall")
    `ASSERT_NEXT(a_degen_id, clk, rst_n, 1'b1,
        !(m_axis_tvalid && m_axis_tuser) || m_axis_tdata == {16'(QMAX), 48'd0},
        "degenerate result is not identity")
    `ASSERT_NEXT(a_valid_shift, clk, rst_n, en && vld_reg[DEPTH-2],
        m_axis_tvalid, "valid bit lost in pipeline")
endmodule

// ===== dv/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

    localparam int FRAC      = 14;
    localparam int ONE       = 1 << FRAC;
    localparam int IDLE_MAX  = 4000;
    localparam int DRAIN_CYC = 40;
    localparam int N_RANDOM  = 830;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic               degen;
    } quat_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic         m_axis_tuser;   // degenerate

    logic [143:0] pending_mats[$];
    quat_t        expected_quats[$];
    int           n_errors;
    int           n_in;
    int           n_out;
    int           n_degen;
    int           idle_cycles;
    int           burst_left;
    int           gap_left;
    int           stall_mode;
    int           stall_phase;

    rotation_matrix_to_quaternion #(.IN_FRAC_BITS(FRAC)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // floor(32767*|c|/sqrt(len2)) with the sign of c, by bitwise search
    function automatic logic [15:0] scaled_component(longint c, longint unsigned len2);
        logic [127:0] mag;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] t;
        logic [15:0]  q;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        rhs = mag * mag * 128'(32767 * 32767);
        q = '0;
        for (int b = 14; b >= 0; b--)
        begin
            t = 128'(q | (16'd1 << b));
            lhs = t * t * 128'(len2);
            if (lhs <= rhs)
                q = t[15:0];
        end
        return (c < 0) ? -q : q;
    endfunction

    function automatic quat_t matrix_to_quat(logic [143:0] d);
        longint         m[3][3];
        longint         q[4];
        longint         tr;
        longint         arg;
        longint unsigned len2;
        int             i;
        int             j;
        int             k;
        logic           degen;
        quat_t          res;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = longint'($signed(d[16*(3*r+c) +: 16]));
        degen = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            q[0] = m[1][2] - m[2][1];
            q[1] = m[2][0] - m[0][2];
            q[2] = m[0][1] - m[1][0];
            q[3] = tr + ONE;
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            arg = m[i][i] - (m[j][j] + m[k][k]) + ONE;
            if (arg <= 0)
            begin
                degen = 1'b1;
                q = '{0, 0, 0, 0};
            end
            else
            begin
                q[i] = arg;
                q[j] = m[i][j] + m[j][i];
                q[k] = m[i][k] + m[k][i];
                q[3] = m[j][k] - m[k][j];
            end
        end
        len2 = 0;
        for (int r = 0; r < 4; r++)
            len2 += longint'(q[r] * q[r]);
        if (len2 == 0)
            degen = 1'b1;
        if (degen)
            res = '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: 16'sd32767, degen: 1'b1};
        else
            res = '{x: scaled_component(q[0], len2), y: scaled_component(q[1], len2),
                    z: scaled_component(q[2], len2), w: scaled_component(q[3], len2),
                    degen: 1'b0};
        return res;
    endfunction

    task automatic report(string field, int exp_val, int got_val);
        n_errors++;
        $display("MISMATCH result %0d %s: expected %0d got %0d", n_out, field, exp_val, got_val);
    endtask

    function automatic logic [143:0] pack_mat(int a0, int a1, int a2, int a3, int a4,
                                               int a5, int a6, int a7, int a8);
        return {a8[15:0], a7[15:0], a6[15:0], a5[15:0], a4[15:0],
                a3[15:0], a2[15:0], a1[15:0], a0[15:0]};
    endfunction

    function automatic int pick_entry(int kind);
        case (kind)
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 2 * ONE) - ONE;
            2: return $urandom_range(0, 512) - 256;
            default:
                case ($urandom_range(0, 4))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    3: return ONE;
                    default: return -ONE;
                endcase
        endcase
    endfunction

    function automatic logic [143:0] random_mat();
        int kind;
        int e[9];
        int dom;
        kind = $urandom_range(0, 4);
        for (int n = 0; n < 9; n++)
            e[n] = pick_entry(kind == 4 ? 1 : kind);
        // dominant diagonal entry with a non-positive trace steers the else branch
        if (kind == 4)
        begin
            dom = $urandom_range(0, 2);
            e[4*dom] = $urandom_range(0, 32767);
            e[4*((dom+1)%3)] = -$urandom_range(16384, 32768);
            e[4*((dom+2)%3)] = -$urandom_range(16384, 32768);
        end
        return pack_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    endfunction

    // sender: bursts and gaps; an offered transaction is held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(pending_mats.pop_front());
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_mats.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_mats[0];
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: ready follows a stall pattern picked at random from four
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode  = 0;
            stall_phase = 0;
        end
        else
        begin
            stall_phase++;
            if (stall_phase % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (stall_phase % 8) < 5;
            endcase
        end
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge clk)
    begin
        quat_t exp_q;
        logic  accepted;
        accepted = 1'b0;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_quats.push_back(matrix_to_quat(s_axis_tdata));
            n_in++;
            accepted = 1'b1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            accepted = 1'b1;
            n_out++;
            if (expected_quats.size() == 0)
                report("unexpected result", 0, 1);
            else
            begin
                exp_q = expected_quats.pop_front();
                if (exp_q.degen) n_degen++;
                if (m_axis_tdata[15:0] !== exp_q.x)
                    report("quat_x", exp_q.x, $signed(m_axis_tdata[15:0]));
                if (m_axis_tdata[31:16] !== exp_q.y)
                    report("quat_y", exp_q.y, $signed(m_axis_tdata[31:16]));
                if (m_axis_tdata[47:32] !== exp_q.z)
                    report("quat_z", exp_q.z, $signed(m_axis_tdata[47:32]));
                if (m_axis_tdata[63:48] !== exp_q.w)
                    report("quat_w", exp_q.w, $signed(m_axis_tdata[63:48]));
                if (m_axis_tuser !== exp_q.degen)
                    report("degenerate", exp_q.degen, m_axis_tuser);
            end
        end
        idle_cycles = accepted ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("tb_rotation_matrix_to_quaternion: errors");
            $finish;
        end
    end

    initial
    begin
        n_errors = 0;
        n_in = 0;
        n_out = 0;
        n_degen = 0;
        idle_cycles = 0;
        // identity, zero, extremes of every entry, each branch, diagonal ties
        pending_mats.push_back(pack_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        pending_mats.push_back(pack_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_mats.push_back(pack_mat(32767, 32767, 32767, 32767, 32767,
                                        32767, 32767, 32767, 32767));
        pending_mats.push_back(pack_mat(-32768, -32768, -32768, -32768, -32768,
                                        -32768, -32768, -32768, -32768));
        pending_mats.push_back(pack_mat(32767, -32768, 32767, -32768, 32767,
                                        -32768, 32767, -32768, 32767));
        pending_mats.push_back(pack_mat(-32768, 32767, -32768, 32767, -32768,
                                        32767, -32768, 32767, -32768));
        pending_mats.push_back(pack_mat(1, 100, -200, 300, 0, -400, 500, 600, -1));
        pending_mats.push_back(pack_mat(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        pending_mats.push_back(pack_mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
        pending_mats.push_back(pack_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
        pending_mats.push_back(pack_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        pending_mats.push_back(pack_mat(0, 1234, -4321, 999, 0, 77, -5, 3000, 0));
        pending_mats.push_back(pack_mat(-100, 50, 60, 70, -100, 80, 90, 10, -200));
        pending_mats.push_back(pack_mat(-300, 50, 60, 70, -300, 80, 90, 10, -300));
        pending_mats.push_back(pack_mat(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE));
        pending_mats.push_back(pack_mat(0, -ONE, 0, ONE, 0, 0, 0, 0, -ONE));
        pending_mats.push_back(pack_mat(32767, 0, 0, 0, -32768, 0, 0, 0, 0));
        pending_mats.push_back(pack_mat(-32768, 32767, 32767, 32767, -32768,
                                        32767, 32767, 32767, 1));
        wait (rst_n);
        // hold off until the directed results are all back
        wait (pending_mats.size() == 0 && !s_axis_tvalid && expected_quats.size() == 0);
        for (int n = 0; n < N_RANDOM; n++)
            pending_mats.push_back(random_mat());
        wait (pending_mats.size() == 0 && !s_axis_tvalid && expected_quats.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        $display("covered trace and all three diagonal branches, ties and extreme entries");
        $display("%0d matrices in, %0d quaternions out, %0d degenerate", n_in, n_out, n_degen);
        if (n_errors == 0 && expected_quats.size() == 0)
            $display("tb_rotation_matrix_to_quaternion: clean");
        else
            $display("tb_rotation_matrix_to_quaternion: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sumsq.sv
sv/rmq_isqrt.sv
sv/rotation_matrix_to_quaternion.sv
dv/tb_rotation_matrix_to_quaternion.sv
